// ===== hdl/tcw_pkg.sv =====
// shared types and constants of the text console writer
package tcw_pkg;

    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 8;
    localparam int CIDX_W  = 11;
    localparam int POS_W   = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_PUT   = 3'd0;
    localparam t_mode MODE_NL    = 3'd1;
    localparam t_mode MODE_ERASE = 3'd2;
    localparam t_mode MODE_COLOR = 3'd3;
    localparam t_mode MODE_CLEAR = 3'd4;
    localparam t_mode MODE_READ  = 3'd5;

    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_NUL      = 8'h00;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [ROW_W-1:0]  stored_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_data;
    } t_res;

endpackage

// ===== hdl/tcw_if.sv =====
// command and result channel interfaces of the text console writer
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    t_mode                mode;
    logic [CHAR_W-1:0]    char_code;
    logic [COLOR_W-1:0]   color;
    logic [COUNT_W-1:0]   erase_count;
    logic [CIDX_W-1:0]    cell_index;

    modport source (output valid, mode, char_code, color, erase_count, cell_index,
                    input ready);
    modport sink   (input valid, mode, char_code, color, erase_count, cell_index,
                    output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_pos;
    logic [ROW_W-1:0]  stored_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;

    modport source (output valid, cursor_pos, stored_row, cursor_col, cell_data,
                    input ready);
    modport sink   (input valid, cursor_pos, stored_row, cursor_col, cell_data,
                    output ready);
endinterface

// ===== hdl/text_mode_console_writer_core.sv =====
// top level of the text-mode console writer: sequencer, frame store and result register
// A command beat on i_cmd updates a SCREEN_WIDTH x SCREEN_HEIGHT character-cell
// frame store (color byte over character byte), the cursor and the current color,
// and gives one result beat on o_res. The frame store has one write and one read
// port, and every walk over it goes one cell per cycle. A scroll and a clear walk
// the whole store; erase writes each erased cell and reads each cell checked to
// its left. A result waiting in the output register does not hold off the next
// command. Read only cells written since reset: the store is not initialized,
// so clear the screen first.
module text_mode_console_writer_core #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_cmd_if.sink    i_cmd,
    tcw_res_if.source  o_res
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    logic              seq_valid;
    t_res              seq_res;
    logic              out_free;
    logic              r_out_valid;
    t_res              r_out;

    tcw_cmd_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .AW            (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_res_valid (seq_valid),
        .o_res       (seq_res),
        .i_res_free  (out_free)
    );

    tcw_frame_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && seq_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_pos = r_out.cursor_pos;
    assign o_res.stored_row = r_out.stored_row;
    assign o_res.cursor_col = r_out.cursor_col;
    assign o_res.cell_data  = r_out.cell_data;

endmodule

// ===== hdl/tcw_frame_ram.sv =====
// character-cell frame store, one write and one registered read per cycle
module tcw_frame_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]    o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcw_cmd_seq.sv =====
// command sequencer: cursor, color and read-modify-write walks over the frame store
module tcw_cmd_seq #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int AW            = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcw_cmd_if.sink                    i_cmd,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [tcw_pkg::CELL_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_rdata,
    output logic                       o_res_valid,
    output tcw_pkg::t_res              o_res,
    input  logic                       i_res_free
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int PW    = $clog2(CELLS + 1);

    localparam logic [PW-1:0] W_P        = PW'(SCREEN_WIDTH);
    localparam logic [PW-1:0] CELLS_P    = PW'(CELLS);
    localparam logic [PW-1:0] CLAST_P    = PW'(CELLS - 1);
    localparam logic [PW-1:0] LAST_ROW_P = PW'(CELLS - SCREEN_WIDTH);
    localparam logic [RW-1:0] H_R        = RW'(SCREEN_HEIGHT);
    localparam logic [RW-1:0] HM1_R      = RW'(SCREEN_HEIGHT - 1);
    localparam logic [CW-1:0] WM1_C      = CW'(SCREEN_WIDTH - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCROLL = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_PUT    = 8'b0000_1000,
        S_ERASE  = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [RW-1:0]        r_row, n_row;
    logic [CW-1:0]        r_col, n_col;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_wptr, n_wptr;
    logic                 r_rd_ok, n_rd_ok;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic [CHAR_W-1:0]    r_fill_char, n_fill_char;
    logic                 r_put, n_put;
    logic                 r_hit, n_hit;
    logic [CELL_W-1:0]    r_data, n_data;

    logic [PW-1:0]        cur_idx;
    logic [RW-1:0]        sb_row;
    logic [CW-1:0]        sb_col;
    logic [PW-1:0]        sb_idx;
    logic [RW-1:0]        vis_row;
    logic [PW-1:0]        vis_idx;
    logic [RW-1:0]        adv_row;
    logic [CW-1:0]        adv_col;

    assign cur_idx = PW'(r_row) * W_P + PW'(r_col);

    // one cell back, staying put at the origin
    always_comb begin
        sb_row = r_row;
        sb_col = r_col;
        if (r_col != '0) begin
            sb_col = r_col - CW'(1);
        end else if (r_row != '0) begin
            sb_row = r_row - RW'(1);
            sb_col = WM1_C;
        end
    end

    assign sb_idx = PW'(sb_row) * W_P + PW'(sb_col);

    // cursor after a put
    always_comb begin
        adv_row = r_row;
        adv_col = r_col + CW'(1);
        if (r_col == WM1_C) begin
            adv_col = '0;
            adv_row = r_row + RW'(1);
        end
    end

    assign vis_row = (r_row >= H_R) ? HM1_R : r_row;
    assign vis_idx = PW'(vis_row) * W_P + PW'(r_col);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_color     = r_color;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_rd_ok     = r_rd_ok;
        n_char      = r_char;
        n_fill_char = r_fill_char;
        n_put       = r_put;
        n_hit       = r_hit;
        n_data      = r_data;
        o_we        = 1'b0;
        o_waddr     = cur_idx[AW-1:0];
        o_wdata     = {r_color, r_char};
        o_re        = 1'b0;
        o_raddr     = r_ptr[AW-1:0];
        o_res_valid = 1'b0;
        i_cmd.ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_data = '0;
                    n_char = i_cmd.char_code;
                    n_state = S_DONE;
                    case (i_cmd.mode)
                        MODE_PUT: begin
                            if (r_row >= H_R) begin
                                n_row       = HM1_R;
                                n_ptr       = W_P;
                                n_rd_ok     = 1'b0;
                                n_put       = 1'b1;
                                n_fill_char = CH_SPACE;
                                n_state     = S_SCROLL;
                            end else begin
                                o_we    = 1'b1;
                                o_wdata = {r_color, i_cmd.char_code};
                                n_row   = adv_row;
                                n_col   = adv_col;
                            end
                        end
                        MODE_NL: begin
                            n_col = '0;
                            if (r_row >= HM1_R) begin
                                n_ptr       = W_P;
                                n_rd_ok     = 1'b0;
                                n_put       = 1'b0;
                                n_fill_char = CH_SPACE;
                                n_state     = S_SCROLL;
                            end else begin
                                n_row = r_row + RW'(1);
                            end
                        end
                        MODE_ERASE: begin
                            n_cnt = i_cmd.erase_count;
                            if (i_cmd.erase_count != '0) begin
                                n_state = S_ERASE;
                            end
                        end
                        MODE_COLOR: begin
                            n_color = i_cmd.color;
                        end
                        MODE_CLEAR: begin
                            n_color     = i_cmd.color;
                            n_row       = '0;
                            n_col       = '0;
                            n_ptr       = '0;
                            n_put       = 1'b0;
                            n_fill_char = CH_NUL;
                            n_state     = S_FILL;
                        end
                        MODE_READ: begin
                            o_re    = 1'b1;
                            o_raddr = AW'(i_cmd.cell_index);
                            n_hit   = int'(i_cmd.cell_index) < CELLS;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                if (r_rd_ok) begin
                    o_we    = 1'b1;
                    o_waddr = r_wptr;
                    o_wdata = i_rdata;
                end
                if (r_ptr == CELLS_P) begin
                    n_ptr   = LAST_ROW_P;
                    n_rd_ok = 1'b0;
                    n_state = S_FILL;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_ptr[AW-1:0];
                    n_wptr  = AW'(r_ptr - W_P);
                    n_ptr   = r_ptr + PW'(1);
                    n_rd_ok = 1'b1;
                end
            end
            S_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_ptr[AW-1:0];
                o_wdata = {r_color, r_fill_char};
                if (r_ptr == CLAST_P) begin
                    n_state = r_put ? S_PUT : S_DONE;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                n_row   = adv_row;
                n_col   = adv_col;
                n_state = S_DONE;
            end
            S_ERASE: begin
                o_we    = 1'b1;
                o_waddr = sb_idx[AW-1:0];
                o_wdata = {r_color, CH_NUL};
                n_row   = sb_row;
                n_col   = sb_col;
                n_cnt   = r_cnt - COUNT_W'(1);
                if (sb_col != '0) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(sb_idx - PW'(1));
                    n_state = S_SCAN;
                end else if (r_cnt == COUNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                // skip back over empty cells on the same row
                if (i_rdata[CHAR_W-1:0] == CH_NUL && r_col != CW'(1)) begin
                    n_col   = r_col - CW'(1);
                    o_re    = 1'b1;
                    o_raddr = AW'(cur_idx - PW'(2));
                end else begin
                    if (i_rdata[CHAR_W-1:0] == CH_NUL) begin
                        n_col = r_col - CW'(1);
                    end
                    n_state = (r_cnt == '0) ? S_DONE : S_ERASE;
                end
            end
            S_READ: begin
                n_data  = r_hit ? i_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.cursor_pos = POS_W'(vis_idx);
    assign o_res.stored_row = ROW_W'(r_row);
    assign o_res.cursor_col = COL_W'(r_col);
    assign o_res.cell_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= COLOR_RESET;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_ptr       <= n_ptr;
        r_wptr      <= n_wptr;
        r_rd_ok     <= n_rd_ok;
        r_char      <= n_char;
        r_fill_char <= n_fill_char;
        r_put       <= n_put;
        r_hit       <= n_hit;
        r_data      <= n_data;
    end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the text-mode console writer core
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int SCR_W = 80;
    localparam int SCR_H = 25;
    localparam int CELLS = SCR_W * SCR_H;
    localparam int ITEMS_TOTAL = 1550;
    localparam int STEADY_ITEMS = 150;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 4 * CELLS + 100;

    localparam t_mode MODE_SPARE_A = 3'd6;
    localparam t_mode MODE_SPARE_B = 3'd7;

    logic i_clk;
    logic i_rst_n;

    tcw_cmd_if cmd_bus ();
    tcw_res_if res_bus ();

    text_mode_console_writer_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // screen mirror and cursor
    logic [CELL_W-1:0]  screen_mem [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] cur_color;

    t_res pending_res[$];
    int   err_cnt;
    int   sent_cnt;
    int   res_cnt;
    int   cycle_cnt;
    logic cmd_idle_en;
    logic res_stall_en;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - SCR_W; i++) begin
            screen_mem[i] = screen_mem[i + SCR_W];
        end
        for (int i = CELLS - SCR_W; i < CELLS; i++) begin
            screen_mem[i] = {cur_color, CH_SPACE};
        end
    endfunction

    function automatic void step_left();
        if (cur_col != 0) begin
            cur_col--;
        end else if (cur_row != 0) begin
            cur_row--;
            cur_col = SCR_W - 1;
        end
    endfunction

    function automatic void write_cursor_cell(logic [CELL_W-1:0] val);
        int idx;
        idx = cur_row * SCR_W + cur_col;
        if (idx < CELLS) begin
            screen_mem[idx] = val;
        end
    endfunction

    function automatic t_res apply_console_cmd(t_mode m, logic [CHAR_W-1:0] ch,
                                               logic [COLOR_W-1:0] color,
                                               logic [COUNT_W-1:0] cnt,
                                               logic [CIDX_W-1:0] cidx);
        t_res r;
        int   vis_row;
        int   left;
        logic stop;
        r.cell_data = '0;
        case (m)
            MODE_PUT: begin
                if (cur_row >= SCR_H) begin
                    scroll_screen();
                    cur_row = SCR_H - 1;
                end
                write_cursor_cell({cur_color, ch});
                cur_col++;
                if (cur_col >= SCR_W) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            MODE_NL: begin
                cur_col = 0;
                if (cur_row + 1 >= SCR_H) begin
                    scroll_screen();
                    if (cur_row > SCR_H) begin
                        cur_row = SCR_H;
                    end
                end else begin
                    cur_row++;
                end
            end
            MODE_ERASE: begin
                for (int i = 0; i < int'(cnt); i++) begin
                    step_left();
                    write_cursor_cell({cur_color, CH_NUL});
                    stop = 1'b0;
                    while (cur_col != 0 && !stop) begin
                        left = cur_row * SCR_W + cur_col - 1;
                        if (left >= CELLS || screen_mem[left][CHAR_W-1:0] != CH_NUL) begin
                            stop = 1'b1;
                        end else begin
                            step_left();
                        end
                    end
                end
            end
            MODE_COLOR: begin
                cur_color = color;
            end
            MODE_CLEAR: begin
                cur_color = color;
                for (int i = 0; i < CELLS; i++) begin
                    screen_mem[i] = {color, CH_NUL};
                end
                cur_row = 0;
                cur_col = 0;
            end
            MODE_READ: begin
                if (int'(cidx) < CELLS) begin
                    r.cell_data = screen_mem[cidx];
                end
            end
            default: begin
            end
        endcase
        vis_row = (cur_row >= SCR_H) ? SCR_H - 1 : cur_row;
        r.cursor_pos = POS_W'(vis_row * SCR_W + cur_col);
        r.stored_row = ROW_W'(cur_row);
        r.cursor_col = COL_W'(cur_col);
        return r;
    endfunction

    // command beats accepted by the block
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            pending_res.push_back(apply_console_cmd(cmd_bus.mode, cmd_bus.char_code,
                                                    cmd_bus.color, cmd_bus.erase_count,
                                                    cmd_bus.cell_index));
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s at result %0d: got 0x%0h, want 0x%0h",
                 what, res_cnt, got, want);
        err_cnt++;
    endtask

    // result beats
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", res_bus.cursor_pos, 0);
            end else begin
                want = pending_res.pop_front();
                if (res_bus.cursor_pos !== want.cursor_pos)
                    report_mismatch("cursor_pos", res_bus.cursor_pos, want.cursor_pos);
                if (res_bus.stored_row !== want.stored_row)
                    report_mismatch("stored_row", res_bus.stored_row, want.stored_row);
                if (res_bus.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", res_bus.cursor_col, want.cursor_col);
                if (res_bus.cell_data !== want.cell_data)
                    report_mismatch("cell_data", res_bus.cell_data, want.cell_data);
            end
            res_cnt++;
        end
    end

    // result side stalls
    initial begin
        forever begin
            if (res_stall_en && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CIDX_W-1:0] rnd_cell();
        return CIDX_W'($urandom_range(0, 2047));
    endfunction

    task automatic send_cmd(input t_mode m, input logic [CHAR_W-1:0] ch,
                            input logic [COLOR_W-1:0] color,
                            input logic [COUNT_W-1:0] cnt,
                            input logic [CIDX_W-1:0] cidx);
        if (cmd_idle_en && $urandom_range(0, 4) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= m;
        cmd_bus.char_code   <= ch;
        cmd_bus.color       <= color;
        cmd_bus.erase_count <= cnt;
        cmd_bus.cell_index  <= cidx;
        do begin
            @(posedge i_clk);
        end while (!cmd_bus.ready);
        sent_cnt++;
    endtask

    task automatic send_put(input logic [CHAR_W-1:0] ch);
        send_cmd(MODE_PUT, ch, rnd8(), rnd8(), rnd_cell());
    endtask

    task automatic send_read(input logic [CIDX_W-1:0] cidx);
        send_cmd(MODE_READ, rnd8(), rnd8(), rnd8(), cidx);
    endtask

    task automatic send_erase(input logic [COUNT_W-1:0] cnt);
        send_cmd(MODE_ERASE, rnd8(), rnd8(), cnt, rnd_cell());
    endtask

    // before the first clear only cell 0 is ever written, so nothing else is read
    task automatic test_reset_state();
        send_put(8'h41);
        send_read('0);
        send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
        send_cmd(MODE_SPARE_A, rnd8(), rnd8(), rnd8(), rnd_cell());
        send_cmd(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0);
    endtask

    task automatic test_field_edges();
        send_erase(8'd3);
        send_erase(8'd0);
        send_put(8'hFF);
        send_put(8'h00);
        send_put(8'h7F);
        send_cmd(MODE_COLOR, rnd8(), 8'hFF, rnd8(), rnd_cell());
        send_put(8'h20);
        send_read(11'd1);
        send_read(11'd3);
        send_erase(8'd255);
        send_read(11'd2);
        send_read(CIDX_W'(CELLS - 1));
        send_read(CIDX_W'(CELLS));
        send_read(11'h7FF);
        send_cmd(MODE_SPARE_B, 8'hFF, 8'hFF, 8'hFF, 11'h7FF);
        send_cmd(MODE_COLOR, rnd8(), 8'h00, rnd8(), rnd_cell());
        send_cmd(MODE_COLOR, rnd8(), 8'h5A, rnd8(), rnd_cell());
        send_cmd(MODE_NL, 8'hFF, 8'hFF, 8'hFF, 11'h7FF);
        send_cmd(MODE_CLEAR, rnd8(), 8'hFF, rnd8(), rnd_cell());
        send_read(11'd0);
    endtask

    // walk the cursor to the bottom, through a pending wrap and both kinds of scroll
    task automatic test_bottom_scroll();
        send_cmd(MODE_CLEAR, rnd8(), rnd8(), rnd8(), rnd_cell());
        repeat (SCR_H - 1) send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
        repeat (SCR_W) send_put(8'($urandom_range(8'h21, 8'h7E)));
        send_read(CIDX_W'(CELLS - 1));
        send_put(8'h2A);
        send_read(CIDX_W'(CELLS - SCR_W - 1));
        repeat (SCR_W - 1) send_put(rnd8());
        send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
        send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
        send_erase(8'd1);
        send_read(CIDX_W'(CELLS - 1));
        send_put(8'h42);
        send_read(CIDX_W'(CELLS - SCR_W));
    endtask

    task automatic test_random_traffic(input int stop_at, input logic allow_idle);
        int pick;
        int len;
        while (sent_cnt < stop_at) begin
            cmd_idle_en  = allow_idle && ($urandom_range(0, 2) != 0);
            res_stall_en = allow_idle && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = $urandom_range(1, 60);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0)
                        send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
                    else if ($urandom_range(0, 3) != 0)
                        send_put(8'($urandom_range(8'h20, 8'h7E)));
                    else
                        send_put(rnd8());
                end
            end else if (pick < 58) begin
                repeat ($urandom_range(1, 4))
                    send_cmd(MODE_NL, rnd8(), rnd8(), rnd8(), rnd_cell());
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 3)) begin
                    len = $urandom_range(0, 7);
                    if (len == 0)
                        send_erase(8'd0);
                    else if (len == 7)
                        send_erase(rnd8());
                    else
                        send_erase(8'($urandom_range(1, 6)));
                end
            end else if (pick < 80) begin
                send_cmd(MODE_COLOR, rnd8(), rnd8(), rnd8(), rnd_cell());
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_read(rnd_cell());
                    else
                        send_read(CIDX_W'($urandom_range(0, CELLS - 1)));
                end
            end else if (pick < 97) begin
                send_cmd($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B,
                         rnd8(), rnd8(), rnd8(), rnd_cell());
            end else begin
                send_cmd(MODE_CLEAR, rnd8(), rnd8(), rnd8(), rnd_cell());
            end
        end
    endtask

    initial begin
        err_cnt      = 0;
        sent_cnt     = 0;
        res_cnt      = 0;
        cycle_cnt    = 0;
        cur_row      = 0;
        cur_col      = 0;
        cur_color    = COLOR_RESET;
        cmd_idle_en  = 1'b1;
        res_stall_en = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            screen_mem[i] = '0;
        end
        i_rst_n             <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.mode        <= MODE_PUT;
        cmd_bus.char_code   <= '0;
        cmd_bus.color       <= '0;
        cmd_bus.erase_count <= '0;
        cmd_bus.cell_index  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_field_edges();
        test_bottom_scroll();
        test_random_traffic(ITEMS_TOTAL - STEADY_ITEMS, 1'b1);
        test_random_traffic(ITEMS_TOTAL, 1'b0);

        cmd_bus.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_frame_ram.sv
hdl/tcw_cmd_seq.sv
hdl/text_mode_console_writer_core.sv
tb/tb.sv
